// ===== hdl/kvt_pkg.sv =====
// Package for the key/value table: request and status codes, the scan token
// carried along the cell row and the write command. No dependencies.
`timescale 1ns / 1ps

package kvt_pkg;

  localparam int KEY_W = 24;
  localparam int VAL_W = 64;
  localparam int IDX_W = 12;  // slot index; covers tables of up to 4096 entries

  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_DEL  = 2'd1;
  localparam logic [1:0] KIND_FIND = 2'd2;

  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // token passed from cell to cell during a scan
  typedef struct packed {
    logic             act;
    logic             hit;
    logic             free;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] free_idx;
    logic [VAL_W-1:0] val;
  } token_t;

  // table update broadcast to all cells
  typedef struct packed {
    logic             wr;
    logic             clr;
    logic [IDX_W-1:0] idx;
  } cmd_t;

endpackage

// ===== hdl/kvt_cell.sv =====
// One slot of the key/value table: holds valid, key and value, checks the
// passing scan token and forwards it. Depends on kvt_pkg.
`timescale 1ns / 1ps

module kvt_cell #(
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [kvt_pkg::KEY_W-1:0] req_key,
  input  logic [kvt_pkg::VAL_W-1:0] req_value,
  input  kvt_pkg::cmd_t             cmd,
  input  kvt_pkg::token_t           tok_in,
  output kvt_pkg::token_t           tok_out
);

  localparam logic [kvt_pkg::IDX_W-1:0] MY_IDX = IDX[kvt_pkg::IDX_W-1:0];

  logic                      valid;
  logic [kvt_pkg::KEY_W-1:0] key;
  logic [kvt_pkg::VAL_W-1:0] value;
  logic                      match;
  logic                      sel;
  kvt_pkg::token_t           tok_next;

  assign match = valid && (key == req_key);
  assign sel   = (cmd.idx == MY_IDX);

  always_comb begin
    tok_next = tok_in;
    if (tok_in.act) begin
      if (match) begin
        tok_next.hit     = 1'b1;
        tok_next.hit_idx = MY_IDX;
        tok_next.val     = value;
      end
      if (!valid && !tok_in.free) begin
        tok_next.free     = 1'b1;
        tok_next.free_idx = MY_IDX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= 1'b0;
      tok_out.act <= 1'b0;
    end else begin
      tok_out.act <= tok_next.act;
      if (cmd.wr && sel) begin
        valid <= 1'b1;
      end else if (cmd.clr && sel) begin
        valid <= 1'b0;
      end
    end
    tok_out.hit      <= tok_next.hit;
    tok_out.free     <= tok_next.free;
    tok_out.hit_idx  <= tok_next.hit_idx;
    tok_out.free_idx <= tok_next.free_idx;
    tok_out.val      <= tok_next.val;
    if (cmd.wr && sel) begin
      key   <= req_key;
      value <= req_value;
    end
  end

endmodule

// ===== hdl/kvt_ctrl.sv =====
// Request sequencer for the key/value table: takes a transaction, launches
// the scan token, decides the update and drives the result. Depends on kvt_pkg.
`timescale 1ns / 1ps

module kvt_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [1:0]                s_kind,
  input  logic [kvt_pkg::KEY_W-1:0] s_key,
  input  logic [kvt_pkg::VAL_W-1:0] s_value,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [1:0]                m_status,
  output logic [kvt_pkg::VAL_W-1:0] m_value,
  output logic [kvt_pkg::KEY_W-1:0] req_key,
  output logic [kvt_pkg::VAL_W-1:0] req_value,
  output kvt_pkg::cmd_t             cmd,
  output kvt_pkg::token_t           tok_head,
  input  kvt_pkg::token_t           tok_tail
);

  kvt_pkg::state_t           state;
  kvt_pkg::state_t           state_next;
  logic [1:0]                kind;
  logic                      start;
  kvt_pkg::token_t           hold;
  kvt_pkg::cmd_t             cmd_next;
  logic                      res_load;
  logic [1:0]                res_status;
  logic [kvt_pkg::VAL_W-1:0] res_value;
  logic                      go;
  logic                      in_acc;

  assign in_acc = s_tvalid && s_tready;

  always_comb begin
    tok_head          = '0;
    tok_head.act      = start;
  end

  always_comb begin
    state_next = state;
    case (state)
      kvt_pkg::S_IDLE: begin
        if (in_acc) state_next = kvt_pkg::S_SCAN;
      end
      kvt_pkg::S_SCAN: begin
        if (tok_tail.act) state_next = kvt_pkg::S_DONE;
      end
      kvt_pkg::S_DONE: begin
        if (go) state_next = kvt_pkg::S_IDLE;
      end
      default: state_next = kvt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd_next   = '0;
    res_load   = 1'b0;
    res_status = kvt_pkg::ST_FOUND;
    res_value  = '0;
    go         = 1'b0;
    case (state)
      kvt_pkg::S_IDLE: begin
        s_tready = 1'b1;
      end
      kvt_pkg::S_DONE: begin
        case (kind)
          kvt_pkg::KIND_ADD: begin
            if (hold.hit) begin
              cmd_next.wr  = 1'b1;
              cmd_next.idx = hold.hit_idx;
            end else if (hold.free) begin
              cmd_next.wr  = 1'b1;
              cmd_next.idx = hold.free_idx;
            end else begin
              res_load   = 1'b1;
              res_status = kvt_pkg::ST_FULL;
            end
          end
          kvt_pkg::KIND_DEL: begin
            cmd_next.clr = hold.hit;
            cmd_next.idx = hold.hit_idx;
          end
          kvt_pkg::KIND_FIND: begin
            res_load = 1'b1;
            if (hold.hit) begin
              res_status = kvt_pkg::ST_FOUND;
              res_value  = hold.val;
            end else begin
              res_status = kvt_pkg::ST_MISSING;
            end
          end
          default: ;
        endcase
        go = !res_load || !m_tvalid || m_tready;
        if (!go) begin
          cmd_next = '0;
          res_load = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= kvt_pkg::S_IDLE;
      start    <= 1'b0;
      cmd      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      start <= in_acc;
      cmd   <= cmd_next;
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind      <= s_kind;
      req_key   <= s_key;
      req_value <= s_value;
    end
    if (state == kvt_pkg::S_SCAN && tok_tail.act) hold <= tok_tail;
    if (res_load) begin
      m_status <= res_status;
      m_value  <= res_value;
    end
  end

`ifndef SYNTHESIS
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr && cmd.clr))
    else $error("write and clear issued together");

  a_acc_scan: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == kvt_pkg::S_SCAN) && start)
    else $error("accepted request did not start a scan");

  a_tail_scan: assert property (@(posedge clk) disable iff (rst)
    tok_tail.act |-> (state == kvt_pkg::S_SCAN))
    else $error("scan token arrived outside a scan");

  a_res_done: assert property (@(posedge clk) disable iff (rst)
    (res_load || cmd_next.wr || cmd_next.clr) |-> (state == kvt_pkg::S_DONE))
    else $error("update or result outside the decision state");
`endif

endmodule

// ===== hdl/key_value_table_add_del_find.sv =====
// Key/value table top level: sequencer plus a row of ENTRIES cells that the
// scan token walks through, one cell per cycle. Depends on kvt_pkg, kvt_ctrl, kvt_cell.
// Result: m_tvalid is raised only for a find and for an add that finds the table full.
// Requests: a new one is accepted only in the idle state, after the token's walk and the decision.
// Reset: synchronous, clears all valid bits (table empty) and the control state.
`timescale 1ns / 1ps

module key_value_table_add_del_find #(
  parameter int ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // [23:0] key, [87:24] value
  input  logic [1:0]  s_tuser,   // [1:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] found_value
  output logic [1:0]  m_tuser    // [1:0] status
);

  logic [kvt_pkg::KEY_W-1:0] req_key;
  logic [kvt_pkg::VAL_W-1:0] req_value;
  kvt_pkg::cmd_t             cmd;
  kvt_pkg::token_t           tok [ENTRIES+1];

  kvt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_kind    (s_tuser),
    .s_key     (s_tdata[23:0]),
    .s_value   (s_tdata[87:24]),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_status  (m_tuser),
    .m_value   (m_tdata),
    .req_key   (req_key),
    .req_value (req_value),
    .cmd       (cmd),
    .tok_head  (tok[0]),
    .tok_tail  (tok[ENTRIES])
  );

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kvt_cell #(
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .req_key   (req_key),
      .req_value (req_value),
      .cmd       (cmd),
      .tok_in    (tok[i]),
      .tok_out   (tok[i+1])
    );
  end

endmodule
